FILE: rtl/core/pvae_pkg.sv
// ----------------------------------------------------------------------------
// Pose velocity estimator package
// Field widths and fixed constants shared by the channel interfaces and core.
// ----------------------------------------------------------------------------
`default_nettype none

package pvae_pkg;

  localparam int PosW   = 24;
  localparam int HeadW  = 17;
  localparam int RateW  = 10;
  localparam int OutW   = 32;
  localparam int CountW = 8;

  localparam int HalfTurn  = 46080;
  localparam int FullTurn  = 92160;
  localparam int CountMax  = 255;
  localparam int RateReset = 30;

endpackage

`default_nettype wire

FILE: rtl/core/pvae_pose_if.sv
// ----------------------------------------------------------------------------
// Pose sample channel
// Valid/ready channel carrying one pose sample per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvae_pose_if;

  logic                                valid;
  logic                                ready;
  logic signed [pvae_pkg::PosW-1:0]    pos_x;
  logic signed [pvae_pkg::PosW-1:0]    pos_y;
  logic signed [pvae_pkg::HeadW-1:0]   heading;

  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/pvae_motion_if.sv
// ----------------------------------------------------------------------------
// Motion result channel
// Valid/ready channel carrying velocity, acceleration and magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvae_motion_if;

  logic                                valid;
  logic                                ready;
  logic signed [pvae_pkg::OutW-1:0]    vel_x;
  logic signed [pvae_pkg::OutW-1:0]    vel_y;
  logic signed [pvae_pkg::OutW-1:0]    vel_turn;
  logic signed [pvae_pkg::OutW-1:0]    acc_x;
  logic signed [pvae_pkg::OutW-1:0]    acc_y;
  logic signed [pvae_pkg::OutW-1:0]    acc_turn;
  logic        [pvae_pkg::OutW-1:0]    speed;
  logic        [pvae_pkg::OutW-1:0]    accel_magnitude;
  logic                                motion_valid;

  modport source (
    output valid, output vel_x, output vel_y, output vel_turn,
    output acc_x, output acc_y, output acc_turn,
    output speed, output accel_magnitude, output motion_valid,
    input  ready
  );
  modport sink (
    input  valid, input vel_x, input vel_y, input vel_turn,
    input  acc_x, input acc_y, input acc_turn,
    input  speed, input accel_magnitude, input motion_valid,
    output ready
  );

endinterface

`default_nettype wire

FILE: rtl/core/pose_velocity_acceleration_estimator_top.sv
// ----------------------------------------------------------------------------
// Pose velocity and acceleration estimator
// Finite-difference velocity, acceleration and magnitudes from pose samples,
// computed on one shared multiplier and a bit-serial square-root step.
// ----------------------------------------------------------------------------
//  channel    dir  handshake        contents
//  pose_i     in   valid/ready      pos_x, pos_y, heading
//  motion_o   out  valid/ready      velocities, accelerations, magnitudes
//  cfg        in   cfg_we_i only    sample_rate_hz
//
//  The first sample after reset only records history (motion_valid low).
//  Later samples use the shared multiplier, then 32-step square roots for
//  speed and, from the third sample on, the acceleration magnitude.
//  pose_i.ready is high only while the sequencer is idle; one result
//  register decouples motion_o, and a stalled result holds the sequencer
//  at its last step. Reset clears all state; sample_rate_hz resets to 30.
// ----------------------------------------------------------------------------
`default_nettype none

module pose_velocity_acceleration_estimator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [pvae_pkg::RateW-1:0]    cfg_data_i,
  pvae_pose_if.sink                          pose_i,
  pvae_motion_if.source                      motion_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_V_LD,
    ST_V_MUL,
    ST_V_WR,
    ST_A_SUB,
    ST_A_MUL,
    ST_A_WR,
    ST_M_LD,
    ST_M_MUL,
    ST_M_ACC,
    ST_SQRT,
    ST_DONE
  } state_e;

  state_e                              state_q;
  logic [pvae_pkg::RateW-1:0]          rate_q;

  logic signed [pvae_pkg::PosW-1:0]    pos_x_q, pos_y_q, prev_x_q, prev_y_q;
  logic signed [pvae_pkg::HeadW-1:0]   head_q, prev_head_q;

  logic signed [31:0]                  vel_q [3];
  logic signed [31:0]                  acc_q [3];
  logic [31:0]                         speed_q, amag_q;
  logic [pvae_pkg::CountW-1:0]         cnt_q;
  logic                                started_q;

  logic [1:0]                          comp_q;
  logic                                term_q;
  logic                                mag_sel_q;
  logic [4:0]                          step_q;

  logic signed [32:0]                  op_q;
  logic signed [65:0]                  prod_q;
  logic [63:0]                         sum_q;
  logic [33:0]                         rem_q;
  logic [31:0]                         root_q;

  logic                                out_valid_q;
  logic signed [31:0]                  out_vel_q [3];
  logic signed [31:0]                  out_acc_q [3];
  logic [31:0]                         out_speed_q, out_amag_q;
  logic                                out_mv_q;

  logic signed [24:0]                  dx_s, dy_s;
  logic signed [17:0]                  dh_raw, dh_s;
  logic signed [32:0]                  d_sel;
  logic signed [32:0]                  opb_s;
  logic signed [65:0]                  prod_d;
  logic signed [31:0]                  sat_s;
  logic signed [31:0]                  mag_src;
  logic [35:0]                         rem_sh, trial;
  logic                                take;
  logic [33:0]                         rem_nx;
  logic [31:0]                         root_nx;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v[65:31] != {35{v[65]}}) begin
      r = v[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_comb begin
    dx_s   = {pos_x_q[pvae_pkg::PosW-1], pos_x_q} - {prev_x_q[pvae_pkg::PosW-1], prev_x_q};
    dy_s   = {pos_y_q[pvae_pkg::PosW-1], pos_y_q} - {prev_y_q[pvae_pkg::PosW-1], prev_y_q};
    dh_raw = {head_q[pvae_pkg::HeadW-1], head_q} - {prev_head_q[pvae_pkg::HeadW-1], prev_head_q};
    if (dh_raw > $signed(18'(pvae_pkg::HalfTurn))) begin
      dh_s = dh_raw - $signed(18'(pvae_pkg::FullTurn));
    end else if (dh_raw < -$signed(18'(pvae_pkg::HalfTurn))) begin
      dh_s = dh_raw + $signed(18'(pvae_pkg::FullTurn));
    end else begin
      dh_s = dh_raw;
    end
    case (comp_q)
      2'd0:    d_sel = 33'(dx_s);
      2'd1:    d_sel = 33'(dy_s);
      default: d_sel = 33'(dh_s);
    endcase
  end

  assign opb_s   = (state_q == ST_M_MUL) ? op_q : $signed({23'b0, rate_q});
  assign prod_d  = op_q * opb_s;
  assign sat_s   = sat32(prod_q);
  assign mag_src = mag_sel_q ? acc_q[{1'b0, term_q}] : vel_q[{1'b0, term_q}];

  assign rem_sh  = {rem_q, sum_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign take    = (rem_sh >= trial);
  assign rem_nx  = take ? 34'(rem_sh - trial) : rem_sh[33:0];
  assign root_nx = {root_q[30:0], take};

  assign pose_i.ready            = (state_q == ST_IDLE);
  assign motion_o.valid          = out_valid_q;
  assign motion_o.vel_x          = out_vel_q[0];
  assign motion_o.vel_y          = out_vel_q[1];
  assign motion_o.vel_turn       = out_vel_q[2];
  assign motion_o.acc_x          = out_acc_q[0];
  assign motion_o.acc_y          = out_acc_q[1];
  assign motion_o.acc_turn       = out_acc_q[2];
  assign motion_o.speed          = out_speed_q;
  assign motion_o.accel_magnitude = out_amag_q;
  assign motion_o.motion_valid   = out_mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= pvae_pkg::RateW'(pvae_pkg::RateReset);
    end else if (cfg_we_i) begin
      rate_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      head_q      <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      prev_head_q <= '0;
      for (int i = 0; i < 3; i++) begin
        vel_q[i]     <= '0;
        acc_q[i]     <= '0;
        out_vel_q[i] <= '0;
        out_acc_q[i] <= '0;
      end
      speed_q     <= '0;
      amag_q      <= '0;
      cnt_q       <= '0;
      started_q   <= 1'b0;
      comp_q      <= '0;
      term_q      <= 1'b0;
      mag_sel_q   <= 1'b0;
      step_q      <= '0;
      op_q        <= '0;
      prod_q      <= '0;
      sum_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
      out_speed_q <= '0;
      out_amag_q  <= '0;
      out_mv_q    <= 1'b0;
    end else begin
      if (motion_o.ready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pose_i.valid) begin
            pos_x_q <= pose_i.pos_x;
            pos_y_q <= pose_i.pos_y;
            head_q  <= pose_i.heading;
            comp_q  <= '0;
            state_q <= started_q ? ST_V_LD : ST_DONE;
          end
        end
        ST_V_LD: begin
          op_q    <= d_sel;
          state_q <= ST_V_MUL;
        end
        ST_V_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_V_WR;
        end
        ST_V_WR: begin
          vel_q[comp_q] <= sat_s;
          op_q          <= 33'(vel_q[comp_q]);
          state_q       <= ST_A_SUB;
        end
        ST_A_SUB: begin
          op_q    <= 33'(vel_q[comp_q]) - op_q;
          state_q <= ST_A_MUL;
        end
        ST_A_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_A_WR;
        end
        ST_A_WR: begin
          if (cnt_q >= pvae_pkg::CountW'(2)) begin
            acc_q[comp_q] <= sat_s;
          end
          if (comp_q == 2'd2) begin
            mag_sel_q <= 1'b0;
            term_q    <= 1'b0;
            state_q   <= ST_M_LD;
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= ST_V_LD;
          end
        end
        ST_M_LD: begin
          op_q    <= mag_src[31] ? -33'(mag_src) : 33'(mag_src);
          state_q <= ST_M_MUL;
        end
        ST_M_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_M_ACC;
        end
        ST_M_ACC: begin
          sum_q <= (term_q ? sum_q : 64'd0) + prod_q[63:0];
          if (term_q) begin
            rem_q   <= '0;
            root_q  <= '0;
            step_q  <= '0;
            state_q <= ST_SQRT;
          end else begin
            term_q  <= 1'b1;
            state_q <= ST_M_LD;
          end
        end
        ST_SQRT: begin
          rem_q  <= rem_nx;
          root_q <= root_nx;
          sum_q  <= {sum_q[61:0], 2'b00};
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) begin
            if (mag_sel_q) begin
              amag_q  <= root_nx;
              state_q <= ST_DONE;
            end else begin
              speed_q <= root_nx;
              if (cnt_q >= pvae_pkg::CountW'(2)) begin
                mag_sel_q <= 1'b1;
                term_q    <= 1'b0;
                state_q   <= ST_M_LD;
              end else begin
                state_q <= ST_DONE;
              end
            end
          end
        end
        ST_DONE: begin
          if (!out_valid_q || motion_o.ready) begin
            prev_x_q    <= pos_x_q;
            prev_y_q    <= pos_y_q;
            prev_head_q <= head_q;
            started_q   <= 1'b1;
            if (!started_q) begin
              cnt_q <= pvae_pkg::CountW'(1);
            end else if (cnt_q < pvae_pkg::CountW'(pvae_pkg::CountMax)) begin
              cnt_q <= cnt_q + pvae_pkg::CountW'(1);
            end
            for (int i = 0; i < 3; i++) begin
              out_vel_q[i] <= vel_q[i];
              out_acc_q[i] <= acc_q[i];
            end
            out_speed_q <= speed_q;
            out_amag_q  <= amag_q;
            out_mv_q    <= started_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pose_i.valid && pose_i.ready) |=> (state_q != ST_IDLE))
    else $error("sequencer idle after accepting an item");

  a_count_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!started_q) |-> (cnt_q == '0))
    else $error("sample count set before first sample");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside final step");

  a_sqrt_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQRT) |-> (rem_q <= {1'b0, root_q, 1'b0}))
    else $error("square-root remainder out of bound");

endmodule

`default_nettype wire
